/* hdl/atlb_pkg.sv */
`timescale 1ns / 1ps

package atlb_pkg;

  localparam int unsigned PidW   = 8;
  localparam int unsigned PageW  = 8;
  localparam int unsigned FrameW = 8;
  localparam int unsigned StampW = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned ModeW  = 3;

  // s_axis_tdata: pid, vpn, frame_in
  localparam int unsigned InDataW  = 24;
  // m_axis_tdata: frame_out, hit total, miss total
  localparam int unsigned OutDataW = 72;

  typedef enum logic [ModeW-1:0] {
    OP_LOOKUP    = 3'd0,
    OP_INSERT    = 3'd1,
    OP_INV_PID   = 3'd2,
    OP_INV_PAGE  = 3'd3,
    OP_CLR_STATS = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [PidW-1:0]   pid;
    logic [PageW-1:0]  page;
    logic [FrameW-1:0] frame;
    logic [StampW-1:0] stamp;
  } entry_t;

  // Running state of one pass around the ring
  typedef struct packed {
    logic              found;
    logic [FrameW-1:0] frame;
    logic              free;
    logic              have_min;
    logic [StampW-1:0] min_stamp;
  } scan_t;

endpackage

/* hdl/atlb_cell.sv */
`timescale 1ns / 1ps

module atlb_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  atlb_pkg::entry_t entry_i,
  output atlb_pkg::entry_t entry_o
);

  logic             valid_q;
  atlb_pkg::entry_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= entry_i;
    end
  end

  always_comb begin
    entry_o       = data_q;
    entry_o.valid = valid_q;
  end

endmodule

/* hdl/atlb_head.sv */
`timescale 1ns / 1ps

module atlb_head #(
  parameter int unsigned IdxW = 4
) (
  input  logic [atlb_pkg::ModeW-1:0]  mode_i,
  input  logic [atlb_pkg::PidW-1:0]   pid_i,
  input  logic [atlb_pkg::PageW-1:0]  page_i,
  input  logic [atlb_pkg::FrameW-1:0] frame_i,
  input  logic [atlb_pkg::StampW-1:0] stamp_i,
  input  logic                        fill_i,
  input  logic [IdxW-1:0]             idx_i,
  input  atlb_pkg::entry_t            entry_i,
  input  atlb_pkg::scan_t             scan_i,
  input  logic [IdxW-1:0]             victim_i,
  output atlb_pkg::entry_t            entry_o,
  output atlb_pkg::scan_t             scan_o,
  output logic [IdxW-1:0]             victim_o
);

  logic pid_hit;
  logic full_hit;

  assign pid_hit  = entry_i.valid && (entry_i.pid == pid_i);
  assign full_hit = pid_hit && (entry_i.page == page_i);

  always_comb begin
    entry_o  = entry_i;
    scan_o   = scan_i;
    victim_o = victim_i;
    unique case (mode_i)
      atlb_pkg::OP_LOOKUP: begin
        // first match in index order wins; restamp it on its way by
        if (!scan_i.found && full_hit) begin
          scan_o.found  = 1'b1;
          scan_o.frame  = entry_i.frame;
          entry_o.stamp = stamp_i;
        end
      end
      atlb_pkg::OP_INSERT: begin
        if (fill_i) begin
          if (idx_i == victim_i) begin
            entry_o.valid = 1'b1;
            entry_o.pid   = pid_i;
            entry_o.page  = page_i;
            entry_o.frame = frame_i;
            entry_o.stamp = stamp_i;
          end
        end else if (!scan_i.free) begin
          if (!entry_i.valid) begin
            scan_o.free = 1'b1;
            victim_o    = idx_i;
          end else if (!scan_i.have_min || (entry_i.stamp < scan_i.min_stamp)) begin
            // strict compare keeps the lowest index on a tie
            scan_o.have_min  = 1'b1;
            scan_o.min_stamp = entry_i.stamp;
            victim_o         = idx_i;
          end
        end
      end
      atlb_pkg::OP_INV_PID: begin
        if (pid_hit) begin
          entry_o.valid = 1'b0;
        end
      end
      atlb_pkg::OP_INV_PAGE: begin
        if (full_hit) begin
          entry_o.valid = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/assoc_tlb_lru.sv */
`timescale 1ns / 1ps
// Fully associative TLB, tagged by process id and page, with LRU replacement.
// Input items arrive on s_axis: tuser carries the operation (lookup, insert,
// invalidate process, invalidate page, clear statistics), tdata the process
// id, page and frame. Every item gives exactly one result on m_axis: tuser is
// the hit flag, tdata the frame and the saturating hit and miss totals.
// The entries sit in a ring of cells that rotates by one place per cycle past
// a single head unit, which compares, restamps, picks victims and clears.
// Lookup and both invalidates take one turn of the ring, insert takes two
// (victim search, then fill). The result is registered in the done state at
// the end of the pass (clear statistics and unused codes go from accept
// straight to done), and the next item is accepted once the block is back
// in idle. One item is in work at a time.
// Reset clears all valid bits, the stamp counter and both totals at once.
// When the receiver stalls, the finished result waits in the output register;
// a following item completes its pass and then waits, with the input closed,
// until that register drains.
module assoc_tlb_lru #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] pid, [15:8] vpn, [23:16] frame_in
  input  logic [atlb_pkg::InDataW-1:0]  s_axis_tdata,
  // [2:0] mode
  input  logic [atlb_pkg::ModeW-1:0]    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] frame_out, [39:8] hit total, [71:40] miss total
  output logic [atlb_pkg::OutDataW-1:0] m_axis_tdata,
  // [0] hit
  output logic                          m_axis_tuser
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  atlb_pkg::state_e state_q, state_d;

  logic [atlb_pkg::ModeW-1:0]  mode_q;
  logic [atlb_pkg::PidW-1:0]   pid_q;
  logic [atlb_pkg::PageW-1:0]  page_q;
  logic [atlb_pkg::FrameW-1:0] frame_q;

  logic [IdxW-1:0]             cnt_q, cnt_d;
  logic [IdxW-1:0]             victim_q, victim_d;
  atlb_pkg::scan_t             scan_q, scan_d;
  logic [atlb_pkg::StampW-1:0] stamp_q, stamp_d;
  logic [atlb_pkg::CountW-1:0] hits_q, hits_d;
  logic [atlb_pkg::CountW-1:0] misses_q, misses_d;

  logic                          out_valid_q, out_valid_d;
  logic [atlb_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic                          out_hit_q, out_hit_d;

  logic             shift;
  logic             accept;
  logic             out_free;
  logic             is_lookup;
  atlb_pkg::entry_t cell_out [ENTRIES];
  atlb_pkg::entry_t head_out;
  atlb_pkg::scan_t  head_scan;
  logic [IdxW-1:0]  head_victim;

  assign s_axis_tready = (state_q == atlb_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign shift         = (state_q == atlb_pkg::ST_SCAN) || (state_q == atlb_pkg::ST_FILL);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign is_lookup     = (mode_q == atlb_pkg::OP_LOOKUP);

  // Ring: cell k takes cell k+1, the last cell takes the head's output
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    atlb_pkg::entry_t cell_in;
    if (k == ENTRIES - 1) begin : g_tail
      assign cell_in = head_out;
    end else begin : g_mid
      assign cell_in = cell_out[k+1];
    end
    atlb_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (cell_in),
      .entry_o (cell_out[k])
    );
  end

  atlb_head #(
    .IdxW (IdxW)
  ) u_head (
    .mode_i   (mode_q),
    .pid_i    (pid_q),
    .page_i   (page_q),
    .frame_i  (frame_q),
    .stamp_i  (stamp_q),
    .fill_i   (state_q == atlb_pkg::ST_FILL),
    .idx_i    (cnt_q),
    .entry_i  (cell_out[0]),
    .scan_i   (scan_q),
    .victim_i (victim_q),
    .entry_o  (head_out),
    .scan_o   (head_scan),
    .victim_o (head_victim)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    scan_d      = scan_q;
    victim_d    = victim_q;
    stamp_d     = stamp_q;
    hits_d      = hits_q;
    misses_d    = misses_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_hit_d   = out_hit_q;
    unique case (state_q)
      atlb_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_d    = '0;
          scan_d   = '0;
          victim_d = '0;
          if (s_axis_tuser == atlb_pkg::OP_LOOKUP || s_axis_tuser == atlb_pkg::OP_INSERT ||
              s_axis_tuser == atlb_pkg::OP_INV_PID || s_axis_tuser == atlb_pkg::OP_INV_PAGE) begin
            state_d = atlb_pkg::ST_SCAN;
          end else begin
            state_d = atlb_pkg::ST_DONE;
          end
        end
      end
      atlb_pkg::ST_SCAN, atlb_pkg::ST_FILL: begin
        scan_d   = head_scan;
        victim_d = head_victim;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          cnt_d = '0;
          if (state_q == atlb_pkg::ST_SCAN && mode_q == atlb_pkg::OP_INSERT) begin
            state_d = atlb_pkg::ST_FILL;
          end else begin
            state_d = atlb_pkg::ST_DONE;
          end
        end
      end
      atlb_pkg::ST_DONE: begin
        // hold here until the output register can take the result
        if (out_free) begin
          if (is_lookup) begin
            if (scan_q.found) begin
              if (hits_q != '1) hits_d = hits_q + 1'b1;
            end else begin
              if (misses_q != '1) misses_d = misses_q + 1'b1;
            end
          end else if (mode_q == atlb_pkg::OP_CLR_STATS) begin
            hits_d   = '0;
            misses_d = '0;
          end
          if ((is_lookup && scan_q.found) || mode_q == atlb_pkg::OP_INSERT) begin
            stamp_d = stamp_q + 1'b1;
          end
          out_valid_d = 1'b1;
          out_hit_d   = is_lookup && scan_q.found;
          out_data_d  = {misses_d, hits_d,
                         (is_lookup && scan_q.found) ? scan_q.frame : '0};
          state_d     = atlb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = atlb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= atlb_pkg::ST_IDLE;
      cnt_q       <= '0;
      stamp_q     <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      stamp_q     <= stamp_d;
      hits_q      <= hits_d;
      misses_q    <= misses_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= s_axis_tuser;
      pid_q   <= s_axis_tdata[7:0];
      page_q  <= s_axis_tdata[15:8];
      frame_q <= s_axis_tdata[23:16];
    end
    scan_q     <= scan_d;
    victim_q   <= victim_d;
    out_data_q <= out_data_d;
    out_hit_q  <= out_hit_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_hit_q;

endmodule

/* hdl/atlb_checker.sv */
`timescale 1ns / 1ps

module atlb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [atlb_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);

  // one item in work at a time: no accept right after an accept
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted while previous one in work");

  a_miss_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("nonzero frame without hit");

  a_hit_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[39:8] != 32'd0))
    else $error("hit reported with zero hit total");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed under stall");

endmodule

bind assoc_tlb_lru atlb_checker u_atlb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
